// File: src/oil_pkg.sv
// Shared types and codes for the ordered identifier list.
// No dependencies; imported by ordered_id_list_with_removal and the testbench.
`timescale 1ns / 1ps

package oil_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 2'd0,
    OP_REMOVE_ID  = 2'd1,
    OP_REMOVE_POS = 2'd2,
    OP_READOUT    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_READ   = 4'b1000
  } seq_state_t;

endpackage : oil_pkg

// File: src/ordered_id_list_with_removal.sv
// Ordered identifier list: append, remove by match, remove at position, read out.
// Append and edits rejected at accept (full, empty, bad position): result next cycle, no busy.
// Remove at position p shifts the later entries down; by id: search from the head, then shift.
// Readout: busy while the entries stream out from the head, one per cycle.
// An edit that goes busy reports in the cycle in which busy falls; one store throughout.
// rst_n (sync, active low) empties the list; store contents are not cleared.
`timescale 1ns / 1ps

module ordered_id_list_with_removal #(
  parameter int unsigned LIST_DEPTH = 16,
  parameter int unsigned ID_BITS    = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command side
  input  logic                           start,
  output logic                           busy,
  input  logic [oil_pkg::OP_W-1:0]       in_op,
  input  logic [oil_pkg::ID_W-1:0]       in_item_id,
  input  logic [oil_pkg::POS_W-1:0]      in_position,
  // result side, one-cycle strobe
  output logic                           out_valid,
  output logic [oil_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_entry_valid,
  output logic [oil_pkg::ID_W-1:0]       out_entry_id,
  output logic [oil_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                           out_last
);

  import oil_pkg::*;

  // Stored id width: only the low ID_BITS of the 32-bit port matter
  localparam int unsigned IdW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int unsigned AW  = $clog2(LIST_DEPTH);
  localparam int unsigned CW  = $clog2(LIST_DEPTH + 1);

  seq_state_t state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [IdW-1:0] key_r, key_nxt;

  // registered result
  logic           vld_r, vld_nxt;
  status_t        status_r, status_nxt;
  logic           ev_r, ev_nxt;
  logic [ID_W-1:0] eid_r, eid_nxt;
  logic           last_r, last_nxt;

  // store port
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [IdW-1:0] wr_data;
  logic [AW-1:0]  rd_addr;
  logic [IdW-1:0] rd_data;

  logic           accept;
  logic           id_match;
  logic           idx_is_tail;
  logic [AW-1:0]  pos_idx;
  op_t            op_in;

  oil_store #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (IdW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign op_in    = op_t'(in_op);
  assign pos_idx  = in_position[AW-1:0];

  // The shared compare: current store word against the search key
  assign id_match    = (rd_data == key_r);
  // idx_r is the last occupied slot
  assign idx_is_tail = ((CW'(idx_r) + CW'(1)) >= count_r);

  // Read address: one ahead of the slot being worked on, two ahead while shifting
  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = (op_in == OP_REMOVE_POS) ? (pos_idx + AW'(1)) : '0;
    end else if (state_r == S_SHIFT) begin
      rd_addr = idx_r + AW'(2);
    end else begin
      rd_addr = idx_r + AW'(1);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    key_nxt    = key_r;
    vld_nxt    = 1'b0;
    status_nxt = ST_DONE;
    ev_nxt     = 1'b0;
    eid_nxt    = '0;
    last_nxt   = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = in_item_id[IdW-1:0];
          case (op_in)
            OP_APPEND: begin
              vld_nxt = 1'b1;
              if (count_r >= CW'(LIST_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_data   = in_item_id[IdW-1:0];
                count_nxt = count_r + CW'(1);
              end
            end
            OP_REMOVE_ID: begin
              idx_nxt = '0;
              if (count_r == '0) begin
                vld_nxt    = 1'b1;
                status_nxt = ST_NOT_FOUND;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            OP_REMOVE_POS: begin
              idx_nxt = pos_idx;
              if (9'(in_position) < 9'(count_r)) begin
                state_nxt = S_SHIFT;
              end else begin
                vld_nxt    = 1'b1;
                status_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              idx_nxt = '0;
              if (count_r == '0) begin
                vld_nxt    = 1'b1;
                status_nxt = ST_NOT_FOUND;
              end else begin
                state_nxt = S_READ;
              end
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (id_match) begin
          state_nxt = S_SHIFT;     // idx_r holds the slot to drop
        end else if (idx_is_tail) begin
          state_nxt  = S_IDLE;
          vld_nxt    = 1'b1;
          status_nxt = ST_NOT_FOUND;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_SHIFT: begin
        // rd_data holds slot idx_r+1
        if (idx_is_tail) begin
          state_nxt = S_IDLE;
          count_nxt = count_r - CW'(1);
          vld_nxt   = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = idx_r;
          wr_data = rd_data;
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_READ: begin
        vld_nxt  = 1'b1;
        ev_nxt   = 1'b1;
        eid_nxt  = ID_W'(rd_data);
        last_nxt = idx_is_tail;
        if (idx_is_tail) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    ev_r     <= ev_nxt;
    eid_r    <= eid_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid       = vld_r;
  assign out_status      = status_r;
  assign out_entry_valid = ev_r;
  assign out_entry_id    = eid_r;
  assign out_entry_count = COUNT_W'(count_r);
  assign out_last        = last_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH))
    else $error("list count beyond depth");

  a_shift_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (CW'(idx_r) < count_r))
    else $error("shift slot outside list");

  a_readout_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_valid && !out_last) |-> busy)
    else $error("readout stopped before last entry");

  a_edit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && idx_is_tail) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("removal did not shorten the list");

endmodule : ordered_id_list_with_removal

// File: src/oil_store.sv
// Entry store: single write port, single read port with registered data.
// Depends on nothing but its parameters; used by ordered_id_list_with_removal.
`timescale 1ns / 1ps

module oil_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule : oil_store

// File: sim/testbench.sv
// Self-checking testbench for ordered_id_list_with_removal.
// Depends on oil_pkg (op and status codes) and the list RTL; drives directed then random
// command transactions and checks every result strobe against an in-bench list predictor.
`timescale 1ns / 1ps

module testbench;
  import oil_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  // drain time after the last transaction (a readout of a full list), plus margin
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned PHASE_ITEMS  = 38;
  localparam int unsigned PLAN_LEN     = 22;

  // one result strobe as the predictor expects it
  typedef struct {
    status_t              status;
    logic                 entry_valid;
    logic [ID_W-1:0]      entry_id;
    logic [COUNT_W-1:0]   entry_count;
    logic                 last;
  } list_result_t;

  // one row of the directed table; reps > 1 appends a run of consecutive ids
  typedef struct {
    op_t                  op;
    logic [ID_W-1:0]      id;
    logic [POS_W-1:0]     pos;
    int unsigned          reps;
    bit                   typed;
    status_t              t_status;
    logic [COUNT_W-1:0]   t_count;
  } list_step_t;

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 start           = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_op           = '0;
  logic [ID_W-1:0]      in_item_id      = '0;
  logic [POS_W-1:0]     in_position     = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_entry_valid;
  logic [ID_W-1:0]      out_entry_id;
  logic [COUNT_W-1:0]   out_entry_count;
  logic                 out_last;

  // predictor state: shadow copy of the list contents and fill level
  logic [ID_W-1:0]      shadow_ids [DEPTH];
  int unsigned          shadow_len = 0;
  list_result_t         pending_results [$];
  int unsigned          mismatches = 0;
  int unsigned          cycle_count = 0;

  // Directed table. Typed rows carry a status/count that is obvious by inspection;
  // the rest (readouts, the fill run) are checked against the predictor.
  list_step_t directed_steps [PLAN_LEN] = '{
    // empty list: readout, both removals report not found
    '{OP_READOUT,    32'h0000_0000, 8'd0,   1, 1'b1, ST_NOT_FOUND, 5'd0},
    '{OP_REMOVE_ID,  32'hFFFF_FFFF, 8'd0,   1, 1'b1, ST_NOT_FOUND, 5'd0},
    '{OP_REMOVE_POS, 32'h0000_0000, 8'd0,   1, 1'b1, ST_NOT_FOUND, 5'd0},
    // id extremes, with a duplicate of all-ones
    '{OP_APPEND,     32'h0000_0000, 8'd0,   1, 1'b1, ST_DONE,      5'd1},
    '{OP_APPEND,     32'hFFFF_FFFF, 8'd0,   1, 1'b1, ST_DONE,      5'd2},
    '{OP_APPEND,     32'hA5A5_5A5A, 8'd0,   1, 1'b1, ST_DONE,      5'd3},
    '{OP_APPEND,     32'hFFFF_FFFF, 8'd0,   1, 1'b1, ST_DONE,      5'd4},
    '{OP_READOUT,    32'h0000_0000, 8'd0,   1, 1'b0, ST_DONE,      5'd0},
    // duplicate: only the entry nearest the head goes
    '{OP_REMOVE_ID,  32'hFFFF_FFFF, 8'd0,   1, 1'b1, ST_DONE,      5'd3},
    // positions out of range: far beyond, and exactly at the count
    '{OP_REMOVE_POS, 32'h0000_0000, 8'hFF,  1, 1'b1, ST_NOT_FOUND, 5'd3},
    '{OP_REMOVE_POS, 32'h0000_0000, 8'd3,   1, 1'b1, ST_NOT_FOUND, 5'd3},
    '{OP_REMOVE_POS, 32'h0000_0000, 8'd2,   1, 1'b1, ST_DONE,      5'd2},
    '{OP_REMOVE_ID,  32'h0000_0000, 8'd0,   1, 1'b1, ST_DONE,      5'd1},
    '{OP_REMOVE_ID,  32'h1234_5678, 8'd0,   1, 1'b1, ST_NOT_FOUND, 5'd1},
    // fill to the brim, then one append too many
    '{OP_APPEND,     32'h8000_0000, 8'd0,  15, 1'b0, ST_DONE,      5'd0},
    '{OP_APPEND,     32'h5555_5555, 8'd0,   1, 1'b1, ST_FULL,      5'd16},
    '{OP_READOUT,    32'h0000_0000, 8'd0,   1, 1'b0, ST_DONE,      5'd0},
    // tail, middle and head removals from a full list
    '{OP_REMOVE_POS, 32'h0000_0000, 8'd15,  1, 1'b1, ST_DONE,      5'd15},
    '{OP_REMOVE_ID,  32'h8000_0007, 8'd0,   1, 1'b1, ST_DONE,      5'd14},
    '{OP_REMOVE_POS, 32'h0000_0000, 8'd0,   1, 1'b1, ST_DONE,      5'd13},
    '{OP_READOUT,    32'h0000_0000, 8'd0,   1, 1'b0, ST_DONE,      5'd0},
    '{OP_REMOVE_POS, 32'h0000_0000, 8'd12,  1, 1'b1, ST_DONE,      5'd12}
  };

  ordered_id_list_with_removal #(
    .LIST_DEPTH (DEPTH),
    .ID_BITS    (ID_W)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_item_id      (in_item_id),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_valid (out_entry_valid),
    .out_entry_id    (out_entry_id),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result of an edit (or of reading an empty list): a single, last strobe.
  function automatic list_result_t edit_result(status_t st, logic [COUNT_W-1:0] cnt);
    list_result_t r;
    r.status      = st;
    r.entry_valid = 1'b0;
    r.entry_id    = '0;
    r.entry_count = cnt;
    r.last        = 1'b1;
    return r;
  endfunction

  // Close the gap left at slot idx, keeping order.
  task automatic drop_slot(int unsigned idx);
    for (int unsigned i = idx; i + 1 < shadow_len; i++) shadow_ids[i] = shadow_ids[i + 1];
    shadow_len--;
  endtask

  // Predictor: apply one accepted transaction to the shadow list and queue its results.
  task automatic apply_list_op(op_t op, logic [ID_W-1:0] id, logic [POS_W-1:0] pos);
    int unsigned  hit;
    list_result_t r;
    hit = DEPTH;
    case (op)
      OP_APPEND: begin
        if (shadow_len >= DEPTH) begin
          pending_results.push_back(edit_result(ST_FULL, COUNT_W'(shadow_len)));
        end else begin
          shadow_ids[shadow_len] = id;
          shadow_len++;
          pending_results.push_back(edit_result(ST_DONE, COUNT_W'(shadow_len)));
        end
      end
      OP_REMOVE_ID: begin
        for (int unsigned i = 0; i < shadow_len; i++)
          if (hit == DEPTH && shadow_ids[i] == id) hit = i;
        if (hit < shadow_len) begin
          drop_slot(hit);
          pending_results.push_back(edit_result(ST_DONE, COUNT_W'(shadow_len)));
        end else begin
          pending_results.push_back(edit_result(ST_NOT_FOUND, COUNT_W'(shadow_len)));
        end
      end
      OP_REMOVE_POS: begin
        if (pos < shadow_len) begin
          drop_slot(pos);
          pending_results.push_back(edit_result(ST_DONE, COUNT_W'(shadow_len)));
        end else begin
          pending_results.push_back(edit_result(ST_NOT_FOUND, COUNT_W'(shadow_len)));
        end
      end
      default: begin
        // readout: one strobe per entry from the head, or a lone not-found when empty
        if (shadow_len == 0) begin
          pending_results.push_back(edit_result(ST_NOT_FOUND, '0));
        end else begin
          for (int unsigned i = 0; i < shadow_len; i++) begin
            r.status      = ST_DONE;
            r.entry_valid = 1'b1;
            r.entry_id    = shadow_ids[i];
            r.entry_count = COUNT_W'(shadow_len);
            r.last        = (i + 1 == shadow_len);
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  // Sender gaps: each cycle the sender idles with probability pct percent.
  // Fields carry junk while start is low.
  task automatic hold_off(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start       <= 1'b0;
      in_op       <= OP_W'($urandom);
      in_item_id  <= $urandom;
      in_position <= POS_W'($urandom);
      @(posedge clk);
    end
  endtask

  // Present one transaction and wait for the edge at which it is taken (start high,
  // busy low as sampled at that edge); the predictor runs at that same edge.
  task automatic send_op(op_t op, logic [ID_W-1:0] id, logic [POS_W-1:0] pos);
    start       <= 1'b1;
    in_op       <= op;
    in_item_id  <= id;
    in_position <= pos;
    do @(posedge clk); while (busy !== 1'b0);
    apply_list_op(op, id, pos);
  endtask

  // Random transaction. Most removals target something that is really in the list;
  // appends draw from a small pool half the time so that duplicates turn up.
  task automatic send_random(int unsigned append_pct);
    int unsigned r;
    op_t         op;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] pos;
    r   = $urandom_range(99);
    id  = $urandom;
    pos = POS_W'($urandom);
    if (r < append_pct) begin
      op = OP_APPEND;
      if ($urandom_range(1) == 0) id = ID_W'($urandom_range(7));
    end else if (r < 85) begin
      op = ($urandom_range(1) == 0) ? OP_REMOVE_ID : OP_REMOVE_POS;
      if (shadow_len > 0 && $urandom_range(99) < 75) begin
        pos = POS_W'($urandom_range(shadow_len - 1));
        id  = shadow_ids[$urandom_range(shadow_len - 1)];
      end else if ($urandom_range(1) == 0) begin
        id  = ID_W'($urandom_range(7));
      end
    end else begin
      op = OP_READOUT;
    end
    send_op(op, id, pos);
  endtask

  task automatic check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Result monitor: every strobe must match the oldest outstanding expectation.
  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none actual status %0h id %0h",
                 $time, out_status, out_entry_id);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status",      exp_r.status,      out_status);
        check_field("entry_valid", exp_r.entry_valid, out_entry_valid);
        check_field("entry_id",    exp_r.entry_id,    out_entry_id);
        check_field("entry_count", exp_r.entry_count, out_entry_count);
        check_field("last",        exp_r.last,        out_last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[ordered_id_list_with_removal] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned idle_pct [3];
    idle_pct = '{20, 61, 0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: typed rows replace the predicted result of that transaction
    foreach (directed_steps[k]) begin
      for (int unsigned rep = 0; rep < directed_steps[k].reps; rep++) begin
        hold_off(idle_pct[0]);
        send_op(directed_steps[k].op, directed_steps[k].id + ID_W'(rep),
                directed_steps[k].pos);
        if (directed_steps[k].typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back(edit_result(directed_steps[k].t_status,
                                                directed_steps[k].t_count));
        end
      end
    end

    // random part: three idling regimes; within each, the list swings between
    // filling up (append-heavy) and draining (removal-heavy)
    for (int unsigned ph = 0; ph < 3; ph++) begin
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        hold_off(idle_pct[ph]);
        send_random(((n / 25) % 2 == 0) ? 65 : 25);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ordered_id_list_with_removal] OK");
    end else begin
      $display("[ordered_id_list_with_removal] ERROR");
    end
    $finish;
  end

endmodule : testbench
